[design/bitmap_id_allocator_unit_defines.svh]
// Assertion macros used by bitmap_id_allocator_unit.
`ifndef BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BIA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bia_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [15:0] free_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] given_id;
  } out_item_t;

endpackage

`default_nettype wire

[design/bia_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/bitmap_id_allocator_unit.sv]
// Channel    | Ports                          | Handshake
// -----------+--------------------------------+--------------------------------
// request    | start, busy, in_item           | taken when start & !busy
// result     | out_valid, out_item            | one-cycle strobe, no back-pressure
//
// Allocate: summary search and word read, then write back.
// Free: word read, then write back; an out-of-range free is answered from idle.
// The used-bit word memory has one port each way; the read-modify-write of one
// word sets the rate. After reset a clearing pass over all (ID_COUNT+63)/64 words
// (512 by default) runs with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_id_allocator_unit_defines.svh"

module bitmap_id_allocator_unit #(
  parameter int ID_COUNT = 32768
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire bia_pkg::in_item_t  in_item,
  output logic                    busy,
  output logic                    out_valid,
  output bia_pkg::out_item_t      out_item
);

  localparam int WORDS  = (ID_COUNT + 63) / 64;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int GROUPS = (WORDS + 63) / 64;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PADW   = GROUPS * 64;
  localparam int TAIL   = ID_COUNT % 64;
  localparam logic [63:0]    LAST_PAD  = (TAIL == 0) ? 64'd0 : ~((64'd1 << TAIL) - 64'd1);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [31:0]    ID_MAX    = 32'(ID_COUNT);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FIND, S_MOD} state_t;

  state_t              state_r;
  logic [WAW-1:0]      clr_r;
  logic [WAW-1:0]      word_r;
  logic [5:0]          bit_r;
  logic                op_r;
  logic [WORDS-1:0]    full_r;
  logic [GROUPS-1:0]   grp_any_r;
  logic [5:0]          grp_idx_r [GROUPS];
  logic                out_valid_r;
  bia_pkg::out_item_t  out_r;

  logic [PADW-1:0]     full_pad;
  logic [GROUPS-1:0]   grp_any_nxt;
  logic [5:0]          grp_idx_nxt [GROUPS];
  logic                found;
  logic [GW-1:0]       gsel;
  logic [GW+5:0]       fw;
  logic [WAW-1:0]      find_word;

  logic [31:0]         id32;
  logic [31:0]         pos32;
  logic                free_ok;
  logic [WAW-1:0]      free_word;
  logic [5:0]          free_bit;

  logic                mem_we;
  logic [WAW-1:0]      mem_waddr;
  logic [63:0]         mem_wdata;
  logic [WAW-1:0]      mem_raddr;
  logic [63:0]         mem_rdata;

  logic [63:0]         masked;
  logic [5:0]          alloc_b;
  logic [63:0]         set_mask;
  logic [63:0]         clr_mask;
  logic                hit;
  logic [31:0]         aid32;

  // summary stage 1: per group of 64 words, any non-full word and the first one
  always_comb begin
    full_pad = '1;
    full_pad[WORDS-1:0] = full_r;
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_nxt[g] = ~&full_pad[g*64 +: 64];
      grp_idx_nxt[g] = 6'd0;
      for (int b = 63; b >= 0; b--) begin
        if (!full_pad[g*64 + b]) begin
          grp_idx_nxt[g] = 6'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_idx_r <= grp_idx_nxt;
  end

  // summary stage 2: lowest group with room
  always_comb begin
    found = 1'b0;
    gsel  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found = 1'b1;
        gsel  = GW'(g);
      end
    end
    fw        = {gsel, grp_idx_r[gsel]};
    find_word = fw[WAW-1:0];
  end

  always_comb begin
    id32      = {16'd0, in_item.free_id};
    pos32     = id32 - 32'd1;
    free_ok   = (id32 != 32'd0) && (id32 <= ID_MAX);
    free_word = pos32[WAW+5:6];
    free_bit  = pos32[5:0];
  end

  always_comb begin
    masked = mem_rdata | ((word_r == LAST_WORD) ? LAST_PAD : 64'd0);
    alloc_b = 6'd0;
    for (int b = 63; b >= 0; b--) begin
      if (!masked[b]) begin
        alloc_b = 6'(b);
      end
    end
    set_mask = 64'd1 << alloc_b;
    clr_mask = 64'd1 << bit_r;
    hit      = |(mem_rdata & clr_mask);
    aid32    = ((32'(word_r) << 6) | 32'(alloc_b)) + 32'd1;
  end

  always_comb begin
    mem_raddr = (state_r == S_IDLE) ? free_word : find_word;
    mem_waddr = (state_r == S_CLEAR) ? clr_r : word_r;
    mem_we    = 1'b0;
    mem_wdata = 64'd0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_MOD: begin
        if (op_r == bia_pkg::OP_ALLOC) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | set_mask;
        end else begin
          mem_we    = hit;
          mem_wdata = mem_rdata & ~clr_mask;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bia_ram #(
    .WIDTH (64),
    .DEPTH (WORDS)
  ) u_words (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_WORD) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r   <= in_item.operation;
            word_r <= free_word;
            bit_r  <= free_bit;
            if (in_item.operation == bia_pkg::OP_ALLOC) begin
              state_r <= S_FIND;
            end else if (free_ok) begin
              state_r <= S_MOD;
            end else begin
              out_valid_r <= 1'b1;
              out_r       <= '{status: bia_pkg::ST_INVALID, given_id: 16'd0};
            end
          end
        end
        S_FIND: begin
          if (found) begin
            word_r  <= find_word;
            state_r <= S_MOD;
          end else begin
            out_valid_r <= 1'b1;
            out_r       <= '{status: bia_pkg::ST_FULL, given_id: 16'd0};
            state_r     <= S_IDLE;
          end
        end
        S_MOD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (op_r == bia_pkg::OP_ALLOC) begin
            full_r[word_r] <= &(masked | set_mask);
            out_r          <= '{status: bia_pkg::ST_OK, given_id: aid32[15:0]};
          end else if (hit) begin
            full_r[word_r] <= 1'b0;
            out_r          <= '{status: bia_pkg::ST_OK, given_id: 16'd0};
          end else begin
            out_r <= '{status: bia_pkg::ST_INVALID, given_id: 16'd0};
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `BIA_ASSERT_SAME(a_clear_busy, state_r == S_CLEAR, busy, "request window open while clearing")
  `BIA_ASSERT_NEXT(a_write_result, mem_we && state_r == S_MOD, out_valid_r, "word update without result")
  `BIA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid_r, "transaction dropped")
  `BIA_ASSERT_SAME(a_fail_no_id, out_valid_r && out_r.status != bia_pkg::ST_OK, out_r.given_id == 16'd0, "identifier on failed result")
  `BIA_ASSERT_SAME(a_find_alloc, state_r == S_FIND, op_r == bia_pkg::OP_ALLOC, "search entered for a free")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int ID_COUNT     = 32768;
  localparam int WORDS        = (ID_COUNT + 63) / 64;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  bia_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  bia_pkg::out_item_t out_item;

  bitmap_id_allocator_unit #(.ID_COUNT(ID_COUNT)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the used-bit map
  logic [63:0] used_words [WORDS];
  int          scan_from;
  logic [15:0] live_ids [$];
  logic [15:0] freed_recent [$];

  bia_pkg::in_item_t  request_q [$];
  bia_pkg::out_item_t expected_results [$];
  int                 sender_idle_pct = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;

  function automatic bia_pkg::out_item_t id_map_apply(bia_pkg::in_item_t t);
    bia_pkg::out_item_t r;
    int w;
    int b;
    int pos;
    bit found;
    r.status   = bia_pkg::ST_FULL;
    r.given_id = '0;
    found      = 1'b0;
    if (t.operation == bia_pkg::OP_ALLOC) begin
      for (w = scan_from; w < WORDS && !found; w++) begin
        if (used_words[w] != '1) begin
          b = 0;
          while (b < 63 && used_words[w][b]) b++;
          pos = w * 64 + b;
          if (pos < ID_COUNT) begin
            used_words[w][b] = 1'b1;
            scan_from  = w;
            r.status   = bia_pkg::ST_OK;
            r.given_id = 16'(pos + 1);
            live_ids.push_back(16'(pos + 1));
          end
          found = 1'b1;
        end
      end
    end else begin
      r.status = bia_pkg::ST_INVALID;
      if (t.free_id != 16'd0 && int'(t.free_id) <= ID_COUNT) begin
        pos = int'(t.free_id) - 1;
        if (used_words[pos / 64][pos % 64]) begin
          used_words[pos / 64][pos % 64] = 1'b0;
          if (pos / 64 < scan_from) scan_from = pos / 64;
          r.status = bia_pkg::ST_OK;
        end
      end
    end
    return r;
  endfunction

  // driver: head of request_q stays on the port until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(id_map_apply(request_q.pop_front()));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_item <= request_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bia_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 50)
          $display("%0t: unexpected result: expected none, actual status %0d id %0d",
                   $time, out_item.status, out_item.given_id);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status) begin
          error_count++;
          if (error_count <= 50)
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_item.status);
        end
        if (out_item.given_id !== want.given_id) begin
          error_count++;
          if (error_count <= 50)
            $display("%0t: given_id mismatch: expected %0d, actual %0d",
                     $time, want.given_id, out_item.given_id);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic enqueue(logic op, logic [15:0] id);
    bia_pkg::in_item_t t;
    t.operation = op;
    t.free_id   = id;
    while (request_q.size() >= 2) @(negedge clk);
    request_q.push_back(t);
  endtask

  task automatic settle();
    while (request_q.size() != 0 || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic random_transaction();
    int r;
    int i;
    logic [15:0] id;
    r = $urandom_range(99);
    if (r < 45 || (r < 85 && live_ids.size() == 0)) begin
      enqueue(bia_pkg::OP_ALLOC, 16'($urandom));
    end else if (r < 85) begin
      i  = $urandom_range(live_ids.size() - 1);
      id = live_ids[i];
      live_ids[i] = live_ids[live_ids.size() - 1];
      void'(live_ids.pop_back());
      freed_recent.push_back(id);
      if (freed_recent.size() > 16) void'(freed_recent.pop_front());
      enqueue(bia_pkg::OP_FREE, id);
    end else if (r < 92 || freed_recent.size() == 0) begin
      enqueue(bia_pkg::OP_FREE, 16'($urandom));
    end else begin
      // double free
      enqueue(bia_pkg::OP_FREE, freed_recent[$urandom_range(freed_recent.size() - 1)]);
    end
  endtask

  initial begin
    int idle_plan [4];
    int p;
    idle_plan = '{0, 47, 0, 15};
    for (p = 0; p < WORDS; p++) used_words[p] = '0;
    scan_from = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: invalid frees, ordering of lowest free id, reuse of holes
    enqueue(bia_pkg::OP_FREE, 16'd0);
    enqueue(bia_pkg::OP_FREE, 16'd1);
    enqueue(bia_pkg::OP_FREE, 16'd32768);
    enqueue(bia_pkg::OP_FREE, 16'd32769);
    enqueue(bia_pkg::OP_FREE, 16'hFFFF);
    enqueue(bia_pkg::OP_ALLOC, 16'd0);
    enqueue(bia_pkg::OP_ALLOC, 16'hFFFF);
    enqueue(bia_pkg::OP_ALLOC, 16'h5A5A);
    enqueue(bia_pkg::OP_FREE, 16'd2);
    enqueue(bia_pkg::OP_FREE, 16'd2);
    enqueue(bia_pkg::OP_ALLOC, 16'hA5A5);
    enqueue(bia_pkg::OP_FREE, 16'd1);
    enqueue(bia_pkg::OP_ALLOC, 16'd1);
    enqueue(bia_pkg::OP_FREE, 16'd3);
    enqueue(bia_pkg::OP_FREE, 16'd4);
    enqueue(bia_pkg::OP_FREE, 16'd1);
    enqueue(bia_pkg::OP_FREE, 16'd2);
    enqueue(bia_pkg::OP_FREE, 16'd3);
    settle();
    live_ids.delete();

    for (p = 0; p < 4; p++) begin
      sender_idle_pct = idle_plan[p];
      repeat (225) random_transaction();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
